// ===== design/ec2d_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ec2d_pkg;

	// field widths
	localparam int CW = 32;                          // coordinate / velocity width
	localparam int MW = 16;                          // mass width
	localparam int IDW = 8 * CW + 2 * MW;            // input request width
	localparam int ODW = ((4 * CW + 2 + 7) / 8) * 8; // result request width

	// fixed-point scale of the unit normal and the mass ratios
	localparam int FRAC = 30;

	// internal widths
	localparam int DW = CW + 1;          // position / velocity difference
	localparam int AW = DW + 3;          // aligned magnitude word
	localparam int NW = FRAC;            // normalized magnitude
	localparam int NSTEP = 6;            // normalizing shift steps 32,16,8,4,2,1
	localparam int NSTEP_TOP = 32;       // first normalizing step
	localparam int RW = FRAC + 1;        // root and quotient width
	localparam int SQ_IN_W = 2 * RW;     // radicand width
	localparam int SQ_REM_W = RW + 2;    // root remainder width
	localparam int SQ_STEPS = RW;        // one root bit per stage
	localparam int DRW = RW + 1;         // divider remainder width
	localparam int DIV_STEPS = RW;       // one quotient bit per stage
	localparam int NLANE = 4;            // nx, ny, m1 ratio, m2 ratio
	localparam int PW = DW;              // |dv * n| magnitude
	localparam int SW = PW + 2;          // signed relative speed
	localparam int TW = SW;              // |2 * s| magnitude
	localparam int FW = TW;              // impulse factor magnitude
	localparam int GW = FW;              // velocity change magnitude
	localparam int OW = GW + 2;          // unsaturated new velocity

	// divider lanes
	localparam int LANE_NX = 0;
	localparam int LANE_NY = 1;
	localparam int LANE_R1 = 2;
	localparam int LANE_R2 = 3;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_COINCIDENT = 2'd1;
	localparam logic [1:0] ST_ZERO_MASS = 2'd2;
	localparam logic [1:0] ST_SATURATED = 2'd3;

	// per-pair data that rides along the pipeline
	typedef struct packed {
		logic signed [CW-1:0] v1x;
		logic signed [CW-1:0] v1y;
		logic signed [CW-1:0] v2x;
		logic signed [CW-1:0] v2y;
		logic [DW-1:0]        dvxm;
		logic [DW-1:0]        dvym;
		logic                 dvxn;
		logic                 dvyn;
		logic                 dxn;
		logic                 dyn;
		logic                 coinc;
		logic                 zmass;
	} side_t;

	typedef struct packed {
		logic [MW-1:0] m1;
		logic [MW-1:0] m2;
		logic [MW:0]   msum;
	} mass_t;

	// magnitude of a signed difference
	function automatic logic [DW-1:0] mag_d(input logic signed [DW-1:0] x);
		logic signed [DW-1:0] n;
		n = -x;
		return x[DW-1] ? DW'(n) : DW'(x);
	endfunction

endpackage

`default_nettype wire

// ===== design/elastic_collision_2d_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel  | dir | payload
// s_*      | in  | body pair: positions, velocities, masses
// m_*      | out | new velocities and status
//
// one pair per clock while s_tready is high
// the depth is mostly set by the 31-stage root pipeline and the 31-stage divider
// pipeline that forms the unit normal and the mass ratios
// arst_n clears all valid bits; payload registers are not reset
// a two-entry output buffer lets the pipeline keep moving after m_tready drops
// until the second entry fills; s_tready falls only when both entries hold a result

module elastic_collision_2d_top
	import ec2d_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	// first_pos_x, first_pos_y, second_pos_x, second_pos_y,
	// first_vel_x, first_vel_y, second_vel_x, second_vel_y, first_mass, second_mass
	input  wire logic [IDW-1:0] s_tdata,
	output logic                m_tvalid,
	input  wire logic           m_tready,
	// new_first_vel_x, new_first_vel_y, new_second_vel_x, new_second_vel_y, status
	output logic [ODW-1:0]      m_tdata
);

	localparam int DEPTH = 7 + SQ_STEPS + DIV_STEPS + 8;

	// pipeline control
	logic             en;
	logic             push;
	logic [DEPTH-1:0] vld_s;
	logic [ODW-1:0]   out_q, skid_q, push_data;
	logic             out_vld_q, skid_vld_q;
	logic             pop;

	// input fields
	logic signed [CW-1:0] in_p1x, in_p1y, in_p2x, in_p2y;
	logic signed [CW-1:0] in_v1x, in_v1y, in_v2x, in_v2y;
	logic [MW-1:0]        in_m1, in_m2;

	// front stages
	logic signed [DW-1:0] dx_s1, dy_s1, dvx_s1, dvy_s1;
	side_t                side_s1, side_c2;
	side_t                side_s2, side_s3, side_s4, side_s5, side_s6, side_s7;
	mass_t                mass_s1, mass_s2, mass_s3, mass_s4, mass_s5, mass_s6, mass_s7;
	logic [DW-1:0]        a_s2, b_s2;
	logic [AW-1:0]        wa_s3, wb_s3, wg_s3;
	logic [AW-1:0]        wa_c4, wb_c4, wg_c4, wa_s4, wb_s4, wg_s4;
	logic [AW-1:0]        wa_c5, wb_c5, wg_c5;
	logic [NW-1:0]        na_s5, nb_s5, na_s6, nb_s6, na_s7, nb_s7;
	logic [2*NW-1:0]      asq_s6, bsq_s6;
	logic [SQ_IN_W-1:0]   x_s7;

	// root pipeline
	logic [SQ_IN_W-1:0]  sq_x_s [SQ_STEPS];
	logic [SQ_REM_W-1:0] sq_rem_s [SQ_STEPS];
	logic [RW-1:0]       sq_root_s [SQ_STEPS];
	logic [NW-1:0]       sq_a_s [SQ_STEPS];
	logic [NW-1:0]       sq_b_s [SQ_STEPS];
	mass_t               sq_mass_s [SQ_STEPS];
	side_t               sq_side_s [SQ_STEPS];
	logic [SQ_IN_W-1:0]  sq_x_c [SQ_STEPS];
	logic [SQ_REM_W-1:0] sq_rem_c [SQ_STEPS];
	logic [RW-1:0]       sq_root_c [SQ_STEPS];

	// divider pipeline
	logic [DRW-1:0] dv_rem_s [DIV_STEPS][NLANE];
	logic [DRW-1:0] dv_den_s [DIV_STEPS][NLANE];
	logic [RW-1:0]  dv_q_s [DIV_STEPS][NLANE];
	side_t          dv_side_s [DIV_STEPS];
	logic [DRW-1:0] dv_rem_c [DIV_STEPS][NLANE];
	logic [DRW-1:0] dv_den_c [DIV_STEPS][NLANE];
	logic [RW-1:0]  dv_q_c [DIV_STEPS][NLANE];

	// back stages
	side_t                side_s8, side_s9, side_s10, side_s11, side_s12, side_s13;
	side_t                side_s14, side_s15;
	logic [RW-1:0]        nxm_s8, nym_s8, r1_s8, r2_s8;
	logic [RW-1:0]        nxm_s9, nym_s9, r1_s9, r2_s9;
	logic [RW-1:0]        nxm_s10, nym_s10, r1_s10, r2_s10;
	logic [RW-1:0]        nxm_s11, nym_s11, r1_s11, r2_s11;
	logic [RW-1:0]        nxm_s12, nym_s12;
	logic [DW+RW-1:0]     mx_c8, my_c8;
	logic [PW-1:0]        pxm_s8, pym_s8;
	logic                 pxn_s8, pyn_s8;
	logic signed [PW:0]   spx_s9, spy_s9;
	logic signed [SW-1:0] ss_s10;
	logic [SW-1:0]        ssm_c11;
	logic [TW-1:0]        tsm_s11;
	logic                 sn_s11, sn_s12;
	logic [TW+RW-1:0]     f1p_c12, f2p_c12;
	logic [FW-1:0]        f1m_s12, f2m_s12;
	logic [FW+RW-1:0]     g1xp_c13, g1yp_c13, g2xp_c13, g2yp_c13;
	logic [GW-1:0]        g1xm_s13, g1ym_s13, g2xm_s13, g2ym_s13;
	logic                 gxn_s13, gyn_s13;
	logic signed [GW:0]   g1x_s14, g1y_s14, g2x_s14, g2y_s14;
	logic signed [OW-1:0] n1x_s15, n1y_s15, n2x_s15, n2y_s15;

	// result forming
	logic [CW:0]   sat1x, sat1y, sat2x, sat2y;
	logic [CW-1:0] o1x, o1y, o2x, o2y;
	logic [1:0]    ostat;

	// clamp to the coordinate range, flag in the top bit
	function automatic logic [CW:0] sat_w(input logic signed [OW-1:0] v);
		logic [OW-CW:0] top;
		top = v[OW-1:CW-1];
		if (top == '0 || top == '1) begin
			return {1'b0, v[CW-1:0]};
		end else if (v[OW-1]) begin
			return {1'b1, 1'b1, {(CW-1){1'b0}}};
		end else begin
			return {1'b1, 1'b0, {(CW-1){1'b1}}};
		end
	endfunction

	// handshake
	assign en       = !skid_vld_q;
	assign s_tready = en;
	assign push     = en && vld_s[DEPTH-1];
	assign pop      = out_vld_q && m_tready;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

	// unpack request
	assign in_p1x = s_tdata[0*CW +: CW];
	assign in_p1y = s_tdata[1*CW +: CW];
	assign in_p2x = s_tdata[2*CW +: CW];
	assign in_p2y = s_tdata[3*CW +: CW];
	assign in_v1x = s_tdata[4*CW +: CW];
	assign in_v1y = s_tdata[5*CW +: CW];
	assign in_v2x = s_tdata[6*CW +: CW];
	assign in_v2y = s_tdata[7*CW +: CW];
	assign in_m1  = s_tdata[8*CW +: MW];
	assign in_m2  = s_tdata[8*CW+MW +: MW];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[DEPTH-2:0], s_tvalid};
		end
	end

	// s1: differences
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1   <= DW'(in_p2x) - DW'(in_p1x);
			dy_s1   <= DW'(in_p2y) - DW'(in_p1y);
			dvx_s1  <= DW'(in_v1x) - DW'(in_v2x);
			dvy_s1  <= DW'(in_v1y) - DW'(in_v2y);
			side_s1 <= '{v1x: in_v1x, v1y: in_v1y, v2x: in_v2x, v2y: in_v2y, default: '0};
			mass_s1 <= '{m1: in_m1, m2: in_m2,
				msum: (MW+1)'(in_m1) + (MW+1)'(in_m2)};
		end
	end

	// s2: magnitudes and special cases
	always_comb begin
		side_c2       = side_s1;
		side_c2.dvxm  = mag_d(dvx_s1);
		side_c2.dvym  = mag_d(dvy_s1);
		side_c2.dvxn  = dvx_s1[DW-1];
		side_c2.dvyn  = dvy_s1[DW-1];
		side_c2.dxn   = dx_s1[DW-1];
		side_c2.dyn   = dy_s1[DW-1];
		side_c2.coinc = (dx_s1 == '0) && (dy_s1 == '0);
		side_c2.zmass = (mass_s1.msum == '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2    <= mag_d(dx_s1);
			b_s2    <= mag_d(dy_s1);
			side_s2 <= side_c2;
			mass_s2 <= mass_s1;
		end
	end

	// s3: larger magnitude, aligned three bits up
	always_ff @(posedge clk) begin
		if (en) begin
			wa_s3   <= {a_s2, 3'b000};
			wb_s3   <= {b_s2, 3'b000};
			wg_s3   <= (a_s2 > b_s2) ? {a_s2, 3'b000} : {b_s2, 3'b000};
			side_s3 <= side_s2;
			mass_s3 <= mass_s2;
		end
	end

	// s4: coarse normalizing shifts
	always_comb begin
		wa_c4 = wa_s3;
		wb_c4 = wb_s3;
		wg_c4 = wg_s3;
		for (int i = 0; i < NSTEP / 2; i++) begin
			if ((wg_c4 >> (AW - (NSTEP_TOP >> i))) == '0) begin
				wa_c4 = wa_c4 << (NSTEP_TOP >> i);
				wb_c4 = wb_c4 << (NSTEP_TOP >> i);
				wg_c4 = wg_c4 << (NSTEP_TOP >> i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wa_s4   <= wa_c4;
			wb_s4   <= wb_c4;
			wg_s4   <= wg_c4;
			side_s4 <= side_s3;
			mass_s4 <= mass_s3;
		end
	end

	// s5: fine normalizing shifts, keep the top bits
	always_comb begin
		wa_c5 = wa_s4;
		wb_c5 = wb_s4;
		wg_c5 = wg_s4;
		for (int i = NSTEP / 2; i < NSTEP; i++) begin
			if ((wg_c5 >> (AW - (NSTEP_TOP >> i))) == '0) begin
				wa_c5 = wa_c5 << (NSTEP_TOP >> i);
				wb_c5 = wb_c5 << (NSTEP_TOP >> i);
				wg_c5 = wg_c5 << (NSTEP_TOP >> i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			na_s5   <= wa_c5[AW-1 -: NW];
			nb_s5   <= wb_c5[AW-1 -: NW];
			side_s5 <= side_s4;
			mass_s5 <= mass_s4;
		end
	end

	// s6: squares
	always_ff @(posedge clk) begin
		if (en) begin
			asq_s6  <= (2*NW)'(na_s5) * (2*NW)'(na_s5);
			bsq_s6  <= (2*NW)'(nb_s5) * (2*NW)'(nb_s5);
			na_s6   <= na_s5;
			nb_s6   <= nb_s5;
			side_s6 <= side_s5;
			mass_s6 <= mass_s5;
		end
	end

	// s7: radicand
	always_ff @(posedge clk) begin
		if (en) begin
			x_s7    <= SQ_IN_W'(asq_s6) + SQ_IN_W'(bsq_s6);
			na_s7   <= na_s6;
			nb_s7   <= nb_s6;
			side_s7 <= side_s6;
			mass_s7 <= mass_s6;
		end
	end

	// root pipeline: one result bit per stage
	always_comb begin
		logic [SQ_IN_W-1:0]  xi;
		logic [SQ_REM_W-1:0] ri;
		logic [RW-1:0]       qi;
		logic [SQ_REM_W+1:0] rt, tr;
		for (int i = 0; i < SQ_STEPS; i++) begin
			if (i == 0) begin
				xi = x_s7;
				ri = '0;
				qi = '0;
			end else begin
				xi = sq_x_s[i-1];
				ri = sq_rem_s[i-1];
				qi = sq_root_s[i-1];
			end
			rt = {ri, xi[SQ_IN_W-1 -: 2]};
			tr = (SQ_REM_W+2)'({qi, 2'b01});
			sq_x_c[i] = xi << 2;
			if (rt >= tr) begin
				sq_rem_c[i]  = SQ_REM_W'(rt - tr);
				sq_root_c[i] = {qi[RW-2:0], 1'b1};
			end else begin
				sq_rem_c[i]  = rt[SQ_REM_W-1:0];
				sq_root_c[i] = {qi[RW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < SQ_STEPS; i++) begin
				sq_x_s[i]    <= sq_x_c[i];
				sq_rem_s[i]  <= sq_rem_c[i];
				sq_root_s[i] <= sq_root_c[i];
				if (i == 0) begin
					sq_a_s[i]    <= na_s7;
					sq_b_s[i]    <= nb_s7;
					sq_mass_s[i] <= mass_s7;
					sq_side_s[i] <= side_s7;
				end else begin
					sq_a_s[i]    <= sq_a_s[i-1];
					sq_b_s[i]    <= sq_b_s[i-1];
					sq_mass_s[i] <= sq_mass_s[i-1];
					sq_side_s[i] <= sq_side_s[i-1];
				end
			end
		end
	end

	// divider pipeline: four lanes, one quotient bit per stage
	always_comb begin
		logic [DRW-1:0] ri, di, t;
		logic [RW-1:0]  qi;
		for (int i = 0; i < DIV_STEPS; i++) begin
			for (int l = 0; l < NLANE; l++) begin
				if (i == 0) begin
					qi = '0;
					case (l)
						LANE_NX: begin
							ri = DRW'(sq_a_s[SQ_STEPS-1]);
							di = DRW'(sq_root_s[SQ_STEPS-1]);
						end
						LANE_NY: begin
							ri = DRW'(sq_b_s[SQ_STEPS-1]);
							di = DRW'(sq_root_s[SQ_STEPS-1]);
						end
						LANE_R1: begin
							ri = DRW'(sq_mass_s[SQ_STEPS-1].m1);
							di = DRW'(sq_mass_s[SQ_STEPS-1].msum);
						end
						default: begin
							ri = DRW'(sq_mass_s[SQ_STEPS-1].m2);
							di = DRW'(sq_mass_s[SQ_STEPS-1].msum);
						end
					endcase
					t = ri;
				end else begin
					ri = dv_rem_s[i-1][l];
					di = dv_den_s[i-1][l];
					qi = dv_q_s[i-1][l];
					t  = ri << 1;
				end
				dv_den_c[i][l] = di;
				if (t >= di) begin
					dv_rem_c[i][l] = t - di;
					dv_q_c[i][l]   = {qi[RW-2:0], 1'b1};
				end else begin
					dv_rem_c[i][l] = t;
					dv_q_c[i][l]   = {qi[RW-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < DIV_STEPS; i++) begin
				for (int l = 0; l < NLANE; l++) begin
					dv_rem_s[i][l] <= dv_rem_c[i][l];
					dv_den_s[i][l] <= dv_den_c[i][l];
					dv_q_s[i][l]   <= dv_q_c[i][l];
				end
				if (i == 0) begin
					dv_side_s[i] <= sq_side_s[SQ_STEPS-1];
				end else begin
					dv_side_s[i] <= dv_side_s[i-1];
				end
			end
		end
	end

	// s8: relative velocity along the normal, per axis
	assign mx_c8 = (DW+RW)'(dv_side_s[DIV_STEPS-1].dvxm) *
		(DW+RW)'(dv_q_s[DIV_STEPS-1][LANE_NX]);
	assign my_c8 = (DW+RW)'(dv_side_s[DIV_STEPS-1].dvym) *
		(DW+RW)'(dv_q_s[DIV_STEPS-1][LANE_NY]);

	always_ff @(posedge clk) begin
		if (en) begin
			pxm_s8  <= mx_c8[FRAC +: PW];
			pym_s8  <= my_c8[FRAC +: PW];
			pxn_s8  <= dv_side_s[DIV_STEPS-1].dvxn ^ dv_side_s[DIV_STEPS-1].dxn;
			pyn_s8  <= dv_side_s[DIV_STEPS-1].dvyn ^ dv_side_s[DIV_STEPS-1].dyn;
			nxm_s8  <= dv_q_s[DIV_STEPS-1][LANE_NX];
			nym_s8  <= dv_q_s[DIV_STEPS-1][LANE_NY];
			r1_s8   <= dv_q_s[DIV_STEPS-1][LANE_R1];
			r2_s8   <= dv_q_s[DIV_STEPS-1][LANE_R2];
			side_s8 <= dv_side_s[DIV_STEPS-1];
		end
	end

	// s9: apply signs
	always_ff @(posedge clk) begin
		if (en) begin
			spx_s9  <= pxn_s8 ? -$signed({1'b0, pxm_s8}) : $signed({1'b0, pxm_s8});
			spy_s9  <= pyn_s8 ? -$signed({1'b0, pym_s8}) : $signed({1'b0, pym_s8});
			nxm_s9  <= nxm_s8;
			nym_s9  <= nym_s8;
			r1_s9   <= r1_s8;
			r2_s9   <= r2_s8;
			side_s9 <= side_s8;
		end
	end

	// s10: relative speed
	always_ff @(posedge clk) begin
		if (en) begin
			ss_s10   <= SW'(spx_s9) + SW'(spy_s9);
			nxm_s10  <= nxm_s9;
			nym_s10  <= nym_s9;
			r1_s10   <= r1_s9;
			r2_s10   <= r2_s9;
			side_s10 <= side_s9;
		end
	end

	// s11: magnitude of twice the speed
	assign ssm_c11 = ss_s10[SW-1] ? SW'(-ss_s10) : SW'(ss_s10);

	always_ff @(posedge clk) begin
		if (en) begin
			tsm_s11  <= {ssm_c11[TW-2:0], 1'b0};
			sn_s11   <= ss_s10[SW-1];
			nxm_s11  <= nxm_s10;
			nym_s11  <= nym_s10;
			r1_s11   <= r1_s10;
			r2_s11   <= r2_s10;
			side_s11 <= side_s10;
		end
	end

	// s12: impulse factors scaled by the mass ratios
	assign f1p_c12 = (TW+RW)'(tsm_s11) * (TW+RW)'(r2_s11);
	assign f2p_c12 = (TW+RW)'(tsm_s11) * (TW+RW)'(r1_s11);

	always_ff @(posedge clk) begin
		if (en) begin
			f1m_s12  <= f1p_c12[FRAC +: FW];
			f2m_s12  <= f2p_c12[FRAC +: FW];
			sn_s12   <= sn_s11;
			nxm_s12  <= nxm_s11;
			nym_s12  <= nym_s11;
			side_s12 <= side_s11;
		end
	end

	// s13: velocity changes along the normal
	assign g1xp_c13 = (FW+RW)'(f1m_s12) * (FW+RW)'(nxm_s12);
	assign g1yp_c13 = (FW+RW)'(f1m_s12) * (FW+RW)'(nym_s12);
	assign g2xp_c13 = (FW+RW)'(f2m_s12) * (FW+RW)'(nxm_s12);
	assign g2yp_c13 = (FW+RW)'(f2m_s12) * (FW+RW)'(nym_s12);

	always_ff @(posedge clk) begin
		if (en) begin
			g1xm_s13 <= g1xp_c13[FRAC +: GW];
			g1ym_s13 <= g1yp_c13[FRAC +: GW];
			g2xm_s13 <= g2xp_c13[FRAC +: GW];
			g2ym_s13 <= g2yp_c13[FRAC +: GW];
			gxn_s13  <= sn_s12 ^ side_s12.dxn;
			gyn_s13  <= sn_s12 ^ side_s12.dyn;
			side_s13 <= side_s12;
		end
	end

	// s14: signed velocity changes
	always_ff @(posedge clk) begin
		if (en) begin
			g1x_s14  <= gxn_s13 ? -$signed({1'b0, g1xm_s13}) : $signed({1'b0, g1xm_s13});
			g1y_s14  <= gyn_s13 ? -$signed({1'b0, g1ym_s13}) : $signed({1'b0, g1ym_s13});
			g2x_s14  <= gxn_s13 ? -$signed({1'b0, g2xm_s13}) : $signed({1'b0, g2xm_s13});
			g2y_s14  <= gyn_s13 ? -$signed({1'b0, g2ym_s13}) : $signed({1'b0, g2ym_s13});
			side_s14 <= side_s13;
		end
	end

	// s15: new velocities before clamping
	always_ff @(posedge clk) begin
		if (en) begin
			n1x_s15  <= OW'(side_s14.v1x) - OW'(g1x_s14);
			n1y_s15  <= OW'(side_s14.v1y) - OW'(g1y_s14);
			n2x_s15  <= OW'(side_s14.v2x) + OW'(g2x_s14);
			n2y_s15  <= OW'(side_s14.v2y) + OW'(g2y_s14);
			side_s15 <= side_s14;
		end
	end

	// clamp, special cases and result packing
	always_comb begin
		sat1x = sat_w(n1x_s15);
		sat1y = sat_w(n1y_s15);
		sat2x = sat_w(n2x_s15);
		sat2y = sat_w(n2y_s15);
		if (side_s15.coinc || side_s15.zmass) begin
			o1x   = side_s15.v1x;
			o1y   = side_s15.v1y;
			o2x   = side_s15.v2x;
			o2y   = side_s15.v2y;
			ostat = side_s15.coinc ? ST_COINCIDENT : ST_ZERO_MASS;
		end else begin
			o1x   = sat1x[CW-1:0];
			o1y   = sat1y[CW-1:0];
			o2x   = sat2x[CW-1:0];
			o2y   = sat2y[CW-1:0];
			ostat = (sat1x[CW] || sat1y[CW] || sat2x[CW] || sat2y[CW]) ?
				ST_SATURATED : ST_OK;
		end
		push_data = ODW'({ostat, o2y, o2x, o1y, o1x});
	end

	// two-entry output buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (pop) begin
			if (skid_vld_q) begin
				skid_vld_q <= push;
			end else begin
				out_vld_q <= push;
			end
		end else if (push) begin
			if (!out_vld_q) begin
				out_vld_q <= 1'b1;
			end else begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_vld_q) begin
				out_q <= skid_q;
				if (push) begin
					skid_q <= push_data;
				end
			end else if (push) begin
				out_q <= push_data;
			end
		end else if (push) begin
			if (!out_vld_q) begin
				out_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

endmodule

`default_nettype wire
